// ===== hdl/ps2tx_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2tx_pkg
// Shared constants, phase codes and the result type of the PS/2 host
// byte transmitter.
// ----------------------------------------------------------------------------
package ps2tx_pkg;

	// Configuration register indexes and widths.
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_INHIBIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP     = 2'd1;

	// Register values after reset.
	localparam logic [CFG_DATA_W-1:0] INHIBIT_RESET = 10'd120;
	localparam logic [CFG_DATA_W-1:0] GAP_RESET     = 10'd200;

	// Bits in one frame: eight data bits and the parity bit.
	localparam logic [3:0] FRAME_BITS = 4'd9;

	// Line-level phase codes.
	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_INHIBIT  = 4'd1;
	localparam logic [3:0] PH_TX_LOW   = 4'd2;
	localparam logic [3:0] PH_TX_HIGH  = 4'd3;
	localparam logic [3:0] PH_ACK_DAT  = 4'd4;
	localparam logic [3:0] PH_ACK_CLK  = 4'd5;
	localparam logic [3:0] PH_ACK_HIGH = 4'd6;
	localparam logic [3:0] PH_RX_LOW   = 4'd7;
	localparam logic [3:0] PH_RX_HIGH  = 4'd8;
	localparam logic [3:0] PH_GAP      = 4'd9;

	// One result beat.
	typedef struct packed {
		logic       clk_drive_low;
		logic       dat_drive_low;
		logic       busy_res;
		logic       done_res;
		logic       ignored;
		logic [8:0] response_bits;
	} res_t;

	// Odd parity over one byte: one when the byte holds an even count of ones.
	function automatic logic odd_parity(input logic [7:0] b);
		return ~(^b);
	endfunction

endpackage

// ===== hdl/ps2tx_tick_if.sv =====
// ----------------------------------------------------------------------------
// ps2tx_tick_if
// Input channel: one beat per tick with the command and the sampled lines.
// ----------------------------------------------------------------------------
interface ps2tx_tick_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] tx_byte;
	logic       clk_in;
	logic       dat_in;

	modport source (output valid, output command, output tx_byte,
		output clk_in, output dat_in, input ready);
	modport sink (input valid, input command, input tx_byte,
		input clk_in, input dat_in, output ready);
endinterface

// ===== hdl/ps2tx_result_if.sv =====
// ----------------------------------------------------------------------------
// ps2tx_result_if
// Output channel: one beat per tick with the line drives and status.
// ----------------------------------------------------------------------------
interface ps2tx_result_if;
	logic       valid;
	logic       ready;
	logic       clk_drive_low;
	logic       dat_drive_low;
	logic       busy_res;
	logic       done_res;
	logic       ignored;
	logic [8:0] response_bits;

	modport source (output valid, output clk_drive_low, output dat_drive_low,
		output busy_res, output done_res, output ignored, output response_bits,
		input ready);
	modport sink (input valid, input clk_drive_low, input dat_drive_low,
		input busy_res, input done_res, input ignored, input response_bits,
		output ready);
endinterface

// ===== hdl/ps2tx_fsm.sv =====
// ----------------------------------------------------------------------------
// ps2tx_fsm
// Line-level state machine. Advances one step per accepted tick and
// produces the result of that tick from the updated state.
// ----------------------------------------------------------------------------
module ps2tx_fsm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                command,
	input  logic [7:0]          tx_byte,
	input  logic                clk_in,
	input  logic                dat_in,
	input  logic [9:0]          inhibit_ticks,
	input  logic [9:0]          gap_ticks,
	output ps2tx_pkg::res_t     res
);

	logic [3:0] phase_q, phase_n;
	logic [8:0] tx_shift_q, tx_shift_n;
	logic [3:0] bit_count_q, bit_count_n;
	logic [9:0] tick_timer_q, tick_timer_n;
	logic [8:0] rx_shift_q, rx_shift_n;
	logic [9:0] timer_inc;
	logic [3:0] bit_inc;
	logic [3:0] tx_sel;
	logic       ign;
	logic       done;
	logic       dat_low;

	assign timer_inc = tick_timer_q + 10'd1;
	assign bit_inc   = bit_count_q + 4'd1;

	// Next-state logic for one tick.
	always_comb begin
		phase_n      = phase_q;
		tx_shift_n   = tx_shift_q;
		bit_count_n  = bit_count_q;
		tick_timer_n = tick_timer_q;
		rx_shift_n   = rx_shift_q;
		done         = 1'b0;
		ign          = (phase_q != ps2tx_pkg::PH_IDLE) && (phase_q <= ps2tx_pkg::PH_GAP)
			&& command;
		unique case (phase_q)
			ps2tx_pkg::PH_INHIBIT: begin
				tick_timer_n = timer_inc;
				if (timer_inc >= inhibit_ticks) begin
					phase_n     = ps2tx_pkg::PH_TX_LOW;
					bit_count_n = 4'd0;
				end
			end
			ps2tx_pkg::PH_TX_LOW: begin
				if (!clk_in) begin
					bit_count_n = bit_inc;
					phase_n     = ps2tx_pkg::PH_TX_HIGH;
				end
			end
			ps2tx_pkg::PH_TX_HIGH: begin
				if (clk_in) begin
					phase_n = (bit_count_q >= ps2tx_pkg::FRAME_BITS) ?
						ps2tx_pkg::PH_ACK_DAT : ps2tx_pkg::PH_TX_LOW;
				end
			end
			ps2tx_pkg::PH_ACK_DAT: begin
				if (!dat_in) phase_n = ps2tx_pkg::PH_ACK_CLK;
			end
			ps2tx_pkg::PH_ACK_CLK: begin
				if (!clk_in) phase_n = ps2tx_pkg::PH_ACK_HIGH;
			end
			ps2tx_pkg::PH_ACK_HIGH: begin
				if (clk_in) begin
					phase_n     = ps2tx_pkg::PH_RX_LOW;
					bit_count_n = 4'd0;
					rx_shift_n  = 9'd0;
				end
			end
			ps2tx_pkg::PH_RX_LOW: begin
				if (!clk_in) begin
					rx_shift_n  = {rx_shift_q[7:0], dat_in};
					bit_count_n = bit_inc;
					phase_n     = ps2tx_pkg::PH_RX_HIGH;
				end
			end
			ps2tx_pkg::PH_RX_HIGH: begin
				if (clk_in) begin
					if (bit_count_q >= ps2tx_pkg::FRAME_BITS) begin
						phase_n      = ps2tx_pkg::PH_GAP;
						tick_timer_n = 10'd0;
					end else begin
						phase_n = ps2tx_pkg::PH_RX_LOW;
					end
				end
			end
			ps2tx_pkg::PH_GAP: begin
				if (tick_timer_q >= gap_ticks) begin
					done    = 1'b1;
					phase_n = ps2tx_pkg::PH_IDLE;
				end else begin
					tick_timer_n = timer_inc;
				end
			end
			default: begin
				// Idle, and any unused code falls back to idle.
				phase_n = ps2tx_pkg::PH_IDLE;
				if (command) begin
					tx_shift_n   = {ps2tx_pkg::odd_parity(tx_byte), tx_byte};
					tick_timer_n = 10'd0;
					bit_count_n  = 4'd0;
					phase_n      = ps2tx_pkg::PH_INHIBIT;
				end
			end
		endcase
	end

	// Data drive while sending: start bit low, then inverted frame bits.
	assign tx_sel = bit_count_n - 4'd1;
	always_comb begin
		dat_low = 1'b0;
		if (phase_n == ps2tx_pkg::PH_TX_LOW || phase_n == ps2tx_pkg::PH_TX_HIGH) begin
			if (bit_count_n == 4'd0) begin
				dat_low = 1'b1;
			end else if (bit_count_n <= ps2tx_pkg::FRAME_BITS) begin
				dat_low = ~tx_shift_n[tx_sel];
			end
		end
	end

	// Result of this tick.
	always_comb begin
		res.clk_drive_low = (phase_n == ps2tx_pkg::PH_INHIBIT);
		res.dat_drive_low = dat_low;
		res.busy_res      = (phase_n != ps2tx_pkg::PH_IDLE);
		res.done_res      = done;
		res.ignored       = ign;
		res.response_bits = rx_shift_n;
	end

	// State registers, advanced on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= ps2tx_pkg::PH_IDLE;
			tx_shift_q   <= 9'd0;
			bit_count_q  <= 4'd0;
			tick_timer_q <= 10'd0;
			rx_shift_q   <= 9'd0;
		end else if (step) begin
			phase_q      <= phase_n;
			tx_shift_q   <= tx_shift_n;
			bit_count_q  <= bit_count_n;
			tick_timer_q <= tick_timer_n;
			rx_shift_q   <= rx_shift_n;
		end
	end

endmodule

// ===== hdl/ps2tx_out_stage.sv =====
// ----------------------------------------------------------------------------
// ps2tx_out_stage
// Result register between the state machine and the output channel.
// Takes a new beat whenever it is empty or its beat leaves this cycle.
// ----------------------------------------------------------------------------
module ps2tx_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ps2tx_pkg::res_t in_res,
	output logic            out_valid,
	input  logic            out_ready,
	output ps2tx_pkg::res_t out_res
);

	logic            valid_q;
	ps2tx_pkg::res_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Payload, loaded on each incoming beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

endmodule

// ===== hdl/ps2_host_byte_transmitter.sv =====
// ----------------------------------------------------------------------------
// ps2_host_byte_transmitter
// PS/2 host-to-device byte transmitter stepped by one-microsecond tick beats.
// ----------------------------------------------------------------------------
// Result: a result beat is registered and valid in the cycle after its tick beat is accepted.
// Throughput: one tick beat per cycle while the result channel is ready; the state update is a
// single pass of compares and shifts, and the result register sits between the two channels.
// Reset: arst_n clears the phase to idle, all counters and shift registers to
// zero, and loads the inhibit and gap registers with 120 and 200.
module ps2_host_byte_transmitter (
	input  logic                                clk,
	input  logic                                arst_n,
	ps2tx_tick_if.sink                          tick,
	ps2tx_result_if.source                      result,
	input  logic                                cfg_we,
	input  logic [ps2tx_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ps2tx_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	logic [9:0]      inhibit_q;
	logic [9:0]      gap_q;
	logic            stage_ready;
	logic            step;
	ps2tx_pkg::res_t core_res;
	ps2tx_pkg::res_t out_res;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inhibit_q <= ps2tx_pkg::INHIBIT_RESET;
			gap_q     <= ps2tx_pkg::GAP_RESET;
		end else if (cfg_we) begin
			if (cfg_index == ps2tx_pkg::REG_INHIBIT) inhibit_q <= cfg_wdata;
			if (cfg_index == ps2tx_pkg::REG_GAP)     gap_q     <= cfg_wdata;
		end
	end

	assign tick.ready = stage_ready;
	assign step       = tick.valid && stage_ready;

	ps2tx_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.command       (tick.command),
		.tx_byte       (tick.tx_byte),
		.clk_in        (tick.clk_in),
		.dat_in        (tick.dat_in),
		.inhibit_ticks (inhibit_q),
		.gap_ticks     (gap_q),
		.res           (core_res)
	);

	ps2tx_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (stage_ready),
		.in_res    (core_res),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_res   (out_res)
	);

	assign result.clk_drive_low = out_res.clk_drive_low;
	assign result.dat_drive_low = out_res.dat_drive_low;
	assign result.busy_res      = out_res.busy_res;
	assign result.done_res      = out_res.done_res;
	assign result.ignored       = out_res.ignored;
	assign result.response_bits = out_res.response_bits;

	// Every accepted tick yields a result beat in the next cycle.
	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> result.valid)
		else $error("accepted tick produced no result beat");

	// A completing transfer is no longer busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.done_res |-> !result.busy_res)
		else $error("done reported while still busy");

	// Clock is held low only during the inhibit, with data released.
	a_inhibit_drive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.clk_drive_low |-> result.busy_res && !result.dat_drive_low)
		else $error("clock drive outside the inhibit window");

	// Done is never reported while a transfer is still running past the inhibit.
	a_start_inhibit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.busy_res && !result.clk_drive_low |-> !result.done_res)
		else $error("done during an active transfer");

endmodule
